[rtl/core/brw_pkg.sv]
// Shared types and constants for the bounded-risk window max-sum block.
// Used by brw_seq, the top level and the port checker; no dependencies.
`default_nettype none

package brw_pkg;

  localparam int unsigned WINDOW_DEPTH = 1024;
  localparam int unsigned VALUE_BITS   = 16;
  localparam int unsigned IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W        = 26;
  localparam int unsigned THR_W        = 11;
  localparam int unsigned CMP_W        = CNT_W + THR_W;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);

  typedef struct packed {
    logic                  is_risky;
    logic [VALUE_BITS-1:0] piece_value;
  } brw_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] window_sum;
    logic [SUM_W-1:0] best_sum;
    logic             refused;
  } brw_out_t;

  // One stored window slot
  typedef struct packed {
    logic                  mark;
    logic [VALUE_BITS-1:0] value;
  } brw_entry_t;

  // Store access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    brw_entry_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } brw_mem_req_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

endpackage

`default_nettype wire

[rtl/core/brw_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module brw_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 17
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/brw_seq.sv]
// Sequencer and datapath: appends words to the store, pops the front on a
// risk overflow, keeps sums and counts. Depends on brw_pkg.
`default_nettype none

module brw_seq import brw_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire brw_in_t      in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output brw_out_t          out_data_o,
  input  wire logic         cfg_we_i,
  input  wire logic [THR_W-1:0] cfg_data_i,
  output brw_mem_req_t      mem_req_o,
  input  wire brw_entry_t   mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] marked_q, marked_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SUM_W-1:0] best_q, best_d;
  logic [THR_W-1:0] thr_q, thr_d;
  logic             refused_q, refused_d;
  logic             out_valid_q, out_valid_d;
  brw_out_t         out_data_q, out_data_d;

  logic [CNT_W-1:0] marked_inc;
  logic [IDX_W-1:0] head_nx;

  assign marked_inc = marked_q + CNT_W'(in_data_i.is_risky);
  assign head_nx    = next_slot(head_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    marked_d    = marked_q;
    sum_d       = sum_q;
    best_d      = best_q;
    refused_d   = refused_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    thr_d       = cfg_we_i ? cfg_data_i : thr_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = tail_q;
    mem_req_o.wdata = '{mark: in_data_i.is_risky, value: in_data_i.piece_value};
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = head_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (count_q == DEPTH_CNT) begin
            // full: refuse and leave the window alone
            refused_d = 1'b1;
            state_d   = S_FIN;
          end else begin
            refused_d    = 1'b0;
            mem_req_o.we = 1'b1;
            tail_d       = next_slot(tail_q);
            count_d      = count_q + 1'b1;
            sum_d        = sum_q + SUM_W'(in_data_i.piece_value);
            marked_d     = marked_inc;
            state_d      = (CMP_W'(marked_inc) > CMP_W'(thr_q)) ? S_READ : S_FIN;
          end
        end
      end
      S_READ: begin
        mem_req_o.re = 1'b1;
        state_d      = S_POP;
      end
      S_POP: begin
        // drop the front word; stop after the oldest marked one
        sum_d   = sum_q - SUM_W'(mem_rdata_i.value);
        head_d  = head_nx;
        count_d = count_q - 1'b1;
        if (mem_rdata_i.mark) begin
          marked_d = marked_q - 1'b1;
          state_d  = S_FIN;
        end else if (count_q == CNT_W'(1)) begin
          state_d = S_FIN;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = head_nx;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          if (!refused_q && (sum_q > best_q)) begin
            best_d = sum_q;
          end
          out_valid_d          = 1'b1;
          out_data_d.window_sum = sum_q;
          out_data_d.best_sum   = (!refused_q && (sum_q > best_q)) ? sum_q : best_q;
          out_data_d.refused    = refused_q;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      marked_q    <= '0;
      sum_q       <= '0;
      best_q      <= '0;
      thr_q       <= '0;
      refused_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      marked_q    <= marked_d;
      sum_q       <= sum_d;
      best_q      <= best_d;
      thr_q       <= thr_d;
      refused_q   <= refused_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[rtl/core/bounded_risk_window_max_sum.sv]
// Top level of the bounded-risk window max-sum block.
// Depends on brw_pkg, brw_ram and brw_seq.
//
// Each accepted word is appended to a FIFO window held in a 1024-entry
// synchronous RAM and yields one result word: the window sum, the best sum
// since reset and a refused flag (set when the window is full; nothing
// changes then). A word that keeps the marked count within risk_threshold
// pops nothing. A word that pushes it over pops front entries up to and
// including the oldest marked one; the single RAM read port pops one entry
// a cycle. Every entry is popped at most once. One word is in work at a
// time; the result register lets the next word enter while a result waits
// on out_stall_i. risk_threshold must be written through cfg_we_i only while
// the block is idle; the block itself does not enforce this. A written
// value takes effect for the next word.
`default_nettype none

module bounded_risk_window_max_sum import brw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire brw_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output brw_out_t              out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [THR_W-1:0] cfg_data_i
);

  brw_mem_req_t                   mem_req;
  logic [$bits(brw_entry_t)-1:0]  ram_rdata;
  brw_entry_t                     mem_rdata;

  assign mem_rdata = brw_entry_t'(ram_rdata);

  brw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  brw_ram #(
    .DEPTH (WINDOW_DEPTH),
    .WIDTH ($bits(brw_entry_t))
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

[rtl/core/brw_checker.sv]
// Port-level checker for bounded_risk_window_max_sum, bound to the top level.
// Depends on brw_pkg.
`default_nettype none

module brw_checker import brw_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire brw_in_t          in_data_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire brw_out_t         out_data_o,
  input wire logic             cfg_we_i,
  input wire logic [THR_W-1:0] cfg_data_i
);

  // a stalled result word stays up
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  // a stalled result word keeps its payload
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // one word in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // best sum never trails the window sum
  a_best_ge_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.best_sum >= out_data_o.window_sum)
    else $error("best sum below window sum");

endmodule

bind bounded_risk_window_max_sum brw_checker u_brw_checker (.*);

`default_nettype wire
